// ===== design/sorted_free_list_record_allocator_unit_defines.svh =====
// Assertion macros used by the record allocator top level.
`ifndef SORTED_FREE_LIST_RECORD_ALLOCATOR_UNIT_DEFINES_SVH
`define SORTED_FREE_LIST_RECORD_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SFL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition in one cycle that implies a property in the next cycle.
`define SFL_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);
`else
`define SFL_ASSERT(lbl, prop, msg)
`define SFL_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

// ===== design/sfl_pkg.sv =====
// Package with sizes, codes and a mask helper for the record allocator.
package sfl_pkg;
   localparam int MAX_RECS  = 1024;
   localparam int WORD_BITS = 32;
   localparam int ROWS      = MAX_RECS / WORD_BITS;
   localparam int ROW_W     = $clog2(ROWS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int SCAN_W    = $clog2(WORD_BITS + 1);
   localparam int CNT_W     = 11;
   localparam int REC_W     = 10;
   localparam int SIZE_W    = 16;
   localparam int RSZ_W     = 13;
   localparam int REG_W     = 13;

   // Operation codes.
   localparam logic [1:0] OP_ALLOC   = 2'd0;
   localparam logic [1:0] OP_RELEASE = 2'd1;
   localparam logic [1:0] OP_CHECK   = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_SPACE = 3'd2;
   localparam logic [2:0] ST_BLOCKED  = 3'd3;
   localparam logic [2:0] ST_INVALID  = 3'd4;

   // Sticky error codes.
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_BAD_SIZE = 2'd1;
   localparam logic [1:0] ERR_NO_SPACE = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_REC_SIZE     = 2'd0;
   localparam logic [1:0] REG_CHUNK_RECS   = 2'd1;
   localparam logic [1:0] REG_INITIAL_RECS = 2'd2;
   localparam logic [1:0] REG_PAGE_RECS    = 2'd3;

   // Register reset values.
   localparam logic [RSZ_W-1:0] REC_SIZE_RST = RSZ_W'(64);
   localparam logic [CNT_W-1:0] RECS_RST     = CNT_W'(64);

   // Scan unit modes.
   localparam logic SCAN_LOWEST = 1'b0;
   localparam logic SCAN_RUN    = 1'b1;

   // Write port of the free map.
   typedef struct packed {
      logic                 en;
      logic [ROW_W-1:0]     row;
      logic [WORD_BITS-1:0] data;
   } map_wr_type;

   // Bits of row r whose record index lies below n.
   function automatic logic [WORD_BITS-1:0] low_mask(input logic [CNT_W-1:0] n,
                                                     input logic [ROW_W-1:0] r);
      logic [CNT_W-BIT_W-1:0] nrow;
      logic [CNT_W-BIT_W-1:0] rr;
      logic [WORD_BITS-1:0]   m;
      nrow = n[CNT_W-1:BIT_W];
      rr   = (CNT_W-BIT_W)'(r);
      if (nrow > rr) begin
         m = '1;
      end else if (nrow == rr) begin
         m = (WORD_BITS'(1) << n[BIT_W-1:0]) - WORD_BITS'(1);
      end else begin
         m = '0;
      end
      return m;
   endfunction
endpackage

// ===== design/sfl_bitmap.sv =====
// Free map memory, one word of record flags per row, with per-row nonempty flags.
module sfl_bitmap import sfl_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  map_wr_type           wr,
   input  logic [ROW_W-1:0]     rd_row,
   output logic [WORD_BITS-1:0] rd_data,
   output logic [ROWS-1:0]      row_nz
);
   logic [WORD_BITS-1:0] mem_ff [ROWS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [ROWS-1:0]      row_nz_ff;

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.row] <= wr.data;
      end
      rd_data_ff <= mem_ff[rd_row];
   end

   // A row holds a free record when its last written word is nonzero.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_nz_ff <= '0;
      end else if (wr.en) begin
         row_nz_ff[wr.row] <= |wr.data;
      end
   end

   assign rd_data = rd_data_ff;
   assign row_nz  = row_nz_ff;
endmodule

// ===== design/sfl_scan.sv =====
// Shared bit scan unit: lowest set bit, or length of a run of ones downward.
module sfl_scan import sfl_pkg::*; (
   input  logic                 mode,
   input  logic [WORD_BITS-1:0] word,
   input  logic [BIT_W-1:0]     lb,
   output logic [SCAN_W-1:0]    cnt
);
   logic [WORD_BITS-1:0] shifted;
   logic [WORD_BITS-1:0] inv;
   logic [WORD_BITS-1:0] src;

   // Bring bit lb to the top; the run of ones then ends at the first zero.
   always_comb begin
      shifted = word << (BIT_W'(WORD_BITS - 1) - lb);
      inv     = ~shifted;
      for (int i = 0; i < WORD_BITS; i++) begin
         src[i] = (mode == SCAN_RUN) ? inv[WORD_BITS-1-i] : word[i];
      end
   end

   // Priority encoder from the low end; all zero gives the word width.
   always_comb begin
      cnt = SCAN_W'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (src[i]) begin
            cnt = SCAN_W'(i);
         end
      end
   end
endmodule

// ===== design/sorted_free_list_record_allocator_unit.sv =====
// Top level: sequencer of the lowest-free-first record allocator.
// A valid check passes through the decode and check states, a valid allocate through
// decode, row find and row write, a release through decode, release and shrink test;
// the result is then held until taken. Growth adds a read and a write state per touched
// free-map row; a tail test adds a read and an evaluate state per row walked and a
// decide state, a cut adds a cut state plus a read and a write state per row rewritten.
// Synchronous reset loads register defaults and runs a fill over every free-map row;
// writing initial_recs reruns that fill. No item is taken during the fill.
`include "sorted_free_list_record_allocator_unit_defines.svh"
module sorted_free_list_record_allocator_unit import sfl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [SIZE_W-1:0] req_request_size,
   input  logic [REC_W-1:0]  req_record,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [REC_W-1:0]  rsp_granted,
   output logic              rsp_is_allocated,
   output logic [CNT_W-1:0]  rsp_free_total,
   output logic [CNT_W-1:0]  rsp_used_total,
   output logic [CNT_W-1:0]  rsp_pool_size,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [REG_W-1:0]  csr_wdata
);
   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_DISP    = 4'd2;
   localparam logic [3:0] S_AL_FIND = 4'd3;
   localparam logic [3:0] S_AL_WR   = 4'd4;
   localparam logic [3:0] S_CHK     = 4'd5;
   localparam logic [3:0] S_REL     = 4'd6;
   localparam logic [3:0] S_SH_CHK  = 4'd7;
   localparam logic [3:0] S_SH_RD   = 4'd8;
   localparam logic [3:0] S_SH_EV   = 4'd9;
   localparam logic [3:0] S_SH_DEC  = 4'd10;
   localparam logic [3:0] S_SH_CUT  = 4'd11;
   localparam logic [3:0] S_RMW_RD  = 4'd12;
   localparam logic [3:0] S_RMW_WR  = 4'd13;
   localparam logic [3:0] S_RESP    = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [REC_W-1:0]  rec_ff, rec_in;
   logic [RSZ_W-1:0]  rec_size_ff, rec_size_in;
   logic [CNT_W-1:0]  chunk_ff, chunk_in;
   logic [CNT_W-1:0]  page_ff, page_in;
   logic [CNT_W-1:0]  pool_ff, pool_in;
   logic [CNT_W-1:0]  free_ff, free_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [1:0]        sticky_ff, sticky_in;
   logic [2:0]        status_ff, status_in;
   logic [REC_W-1:0]  granted_ff, granted_in;
   logic              alloc_ff, alloc_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [ROW_W-1:0]  hi_row_ff, hi_row_in;
   logic [BIT_W-1:0]  lb_ff, lb_in;
   logic [CNT_W-1:0]  run_ff, run_in;
   logic [CNT_W-1:0]  mn_ff, mn_in;
   logic [CNT_W-1:0]  mx_ff, mx_in;
   logic              grow_ff, grow_in;
   logic [CNT_W-1:0]  cut_ff, cut_in;

   map_wr_type           map_wr;
   logic [ROW_W-1:0]     rd_row;
   logic [WORD_BITS-1:0] rd_data;
   logic [ROWS-1:0]      row_nz;
   logic                 scan_mode;
   logic [WORD_BITS-1:0] scan_word;
   logic [BIT_W-1:0]     scan_lb;
   logic [SCAN_W-1:0]    scan_cnt;

   logic [CNT_W-1:0]     c_eff;
   logic [CNT_W:0]       grow_sum;
   logic [CNT_W:0]       grow_last;
   logic [CNT_W-1:0]     last_rec;
   logic [CNT_W-1:0]     tail_dist;
   logic [CNT_W-1:0]     other;
   logic [CNT_W-1:0]     new_pool;
   logic [CNT_W-1:0]     init_sat;
   logic [BIT_W-1:0]     rec_bit;
   logic [ROW_W-1:0]     rec_row;

   sfl_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .wr      (map_wr),
      .rd_row  (rd_row),
      .rd_data (rd_data),
      .row_nz  (row_nz)
   );

   sfl_scan u_scan (
      .mode (scan_mode),
      .word (scan_word),
      .lb   (scan_lb),
      .cnt  (scan_cnt)
   );

   // Derived values used across the sequencer.
   always_comb begin
      c_eff     = (chunk_ff == '0) ? CNT_W'(1) : chunk_ff;
      grow_sum  = {1'b0, pool_ff} + {1'b0, c_eff};
      grow_last = grow_sum - (CNT_W+1)'(1);
      last_rec  = pool_ff - CNT_W'(1);
      tail_dist = run_ff - CNT_W'(1);
      other     = free_ff - tail_dist;
      new_pool  = pool_ff - cut_ff;
      rec_bit   = rec_ff[BIT_W-1:0];
      rec_row   = rec_ff[REC_W-1:BIT_W];
      if (csr_wdata[CNT_W-1:0] == '0) begin
         init_sat = CNT_W'(1);
      end else if (csr_wdata[CNT_W-1:0] > CNT_W'(MAX_RECS)) begin
         init_sat = CNT_W'(MAX_RECS);
      end else begin
         init_sat = csr_wdata[CNT_W-1:0];
      end
   end

   // Scan unit input selection by sequencer step.
   always_comb begin
      scan_mode = SCAN_LOWEST;
      scan_word = rd_data;
      scan_lb   = lb_ff;
      case (state_ff)
         S_AL_FIND: begin
            scan_word = WORD_BITS'(row_nz);
         end
         S_SH_EV: begin
            scan_mode = SCAN_RUN;
         end
         default: begin
         end
      endcase
   end

   // Sequencer next state and datapath updates.
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      size_in     = size_ff;
      rec_in      = rec_ff;
      rec_size_in = rec_size_ff;
      chunk_in    = chunk_ff;
      page_in     = page_ff;
      pool_in     = pool_ff;
      free_in     = free_ff;
      used_in     = used_ff;
      sticky_in   = sticky_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      alloc_in    = alloc_ff;
      cur_row_in  = cur_row_ff;
      hi_row_in   = hi_row_ff;
      lb_in       = lb_ff;
      run_in      = run_ff;
      mn_in       = mn_ff;
      mx_in       = mx_ff;
      grow_in     = grow_ff;
      cut_in      = cut_ff;
      rd_row      = cur_row_ff;
      map_wr.en   = 1'b0;
      map_wr.row  = cur_row_ff;
      map_wr.data = rd_data;

      case (state_ff)
         // Fill pass: records below the pool size start free.
         S_INIT: begin
            map_wr.en   = 1'b1;
            map_wr.data = low_mask(pool_ff, cur_row_ff);
            cur_row_in  = cur_row_ff + ROW_W'(1);
            if (cur_row_ff == ROW_W'(ROWS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               size_in  = req_request_size;
               rec_in   = req_record;
               state_in = S_DISP;
            end
         end
         // Decode the request; reads of the record row are issued here.
         S_DISP: begin
            rd_row     = rec_row;
            cur_row_in = rec_row;
            status_in  = ST_OK;
            granted_in = '0;
            alloc_in   = 1'b0;
            state_in   = S_RESP;
            case (op_ff)
               OP_ALLOC: begin
                  if (sticky_ff != ERR_NONE) begin
                     status_in = ST_BLOCKED;
                  end else if (size_ff > SIZE_W'(rec_size_ff)) begin
                     sticky_in = ERR_BAD_SIZE;
                     status_in = ST_BAD_SIZE;
                  end else if (free_ff == '0) begin
                     if (grow_sum > (CNT_W+1)'(MAX_RECS)) begin
                        sticky_in = ERR_NO_SPACE;
                        status_in = ST_NO_SPACE;
                     end else begin
                        mn_in      = pool_ff;
                        mx_in      = grow_sum[CNT_W-1:0];
                        pool_in    = grow_sum[CNT_W-1:0];
                        free_in    = free_ff + c_eff;
                        grow_in    = 1'b1;
                        cur_row_in = pool_ff[REC_W-1:BIT_W];
                        hi_row_in  = grow_last[REC_W-1:BIT_W];
                        state_in   = S_RMW_RD;
                     end
                  end else begin
                     state_in = S_AL_FIND;
                  end
               end
               OP_RELEASE: begin
                  if (sticky_ff != ERR_NONE) begin
                     status_in = ST_BLOCKED;
                  end else if ({1'b0, rec_ff} >= pool_ff) begin
                     status_in = ST_INVALID;
                  end else begin
                     state_in = S_REL;
                  end
               end
               OP_CHECK: begin
                  if ({1'b0, rec_ff} >= pool_ff) begin
                     status_in = ST_INVALID;
                  end else begin
                     state_in = S_CHK;
                  end
               end
               default: begin
               end
            endcase
         end
         // Lowest row with a free record, then read it.
         S_AL_FIND: begin
            rd_row     = scan_cnt[ROW_W-1:0];
            cur_row_in = scan_cnt[ROW_W-1:0];
            state_in   = S_AL_WR;
         end
         // Lowest free record in that row is taken.
         S_AL_WR: begin
            map_wr.en   = 1'b1;
            map_wr.data = rd_data & ~(WORD_BITS'(1) << scan_cnt[BIT_W-1:0]);
            granted_in  = {cur_row_ff, scan_cnt[BIT_W-1:0]};
            free_in     = free_ff - CNT_W'(1);
            used_in     = used_ff + CNT_W'(1);
            state_in    = S_RESP;
         end
         S_CHK: begin
            alloc_in = ~rd_data[rec_bit];
            state_in = S_RESP;
         end
         S_REL: begin
            if (rd_data[rec_bit]) begin
               status_in = ST_INVALID;
               state_in  = S_RESP;
            end else begin
               map_wr.en   = 1'b1;
               map_wr.data = rd_data | (WORD_BITS'(1) << rec_bit);
               free_in     = free_ff + CNT_W'(1);
               used_in     = used_ff - CNT_W'(1);
               state_in    = S_SH_CHK;
            end
         end
         // Shrink only when free records exceed twice the chunk.
         S_SH_CHK: begin
            if ({1'b0, free_ff} > {c_eff, 1'b0}) begin
               cur_row_in = last_rec[REC_W-1:BIT_W];
               lb_in      = last_rec[BIT_W-1:0];
               run_in     = '0;
               state_in   = S_SH_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_SH_RD: begin
            state_in = S_SH_EV;
         end
         // Extend the free tail run; continue to the row below if it spans the row.
         S_SH_EV: begin
            run_in = run_ff + CNT_W'(scan_cnt);
            if (scan_cnt == SCAN_W'(lb_ff) + SCAN_W'(1) && cur_row_ff != '0) begin
               cur_row_in = cur_row_ff - ROW_W'(1);
               lb_in      = BIT_W'(WORD_BITS - 1);
               state_in   = S_SH_RD;
            end else begin
               state_in = S_SH_DEC;
            end
         end
         // Decide on the cut length.
         S_SH_DEC: begin
            if (run_ff == '0 || tail_dist < c_eff || tail_dist < page_ff) begin
               state_in = S_RESP;
            end else begin
               cut_in   = (other > c_eff) ? tail_dist : (free_ff - c_eff);
               state_in = S_SH_CUT;
            end
         end
         S_SH_CUT: begin
            mn_in      = new_pool;
            mx_in      = pool_ff;
            grow_in    = 1'b0;
            cur_row_in = new_pool[REC_W-1:BIT_W];
            hi_row_in  = last_rec[REC_W-1:BIT_W];
            pool_in    = new_pool;
            free_in    = free_ff - cut_ff;
            state_in   = S_RMW_RD;
         end
         S_RMW_RD: begin
            state_in = S_RMW_WR;
         end
         // Set the grown range, or clear everything at and above the new size.
         S_RMW_WR: begin
            map_wr.en = 1'b1;
            if (grow_ff) begin
               map_wr.data = rd_data | (low_mask(mx_ff, cur_row_ff) &
                                        ~low_mask(mn_ff, cur_row_ff));
            end else begin
               map_wr.data = rd_data & low_mask(mn_ff, cur_row_ff);
            end
            if (cur_row_ff == hi_row_ff) begin
               state_in = grow_ff ? S_AL_FIND : S_RESP;
            end else begin
               cur_row_in = cur_row_ff + ROW_W'(1);
               state_in   = S_RMW_RD;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Register writes; a new initial size restarts the pool.
      if (csr_wr_en) begin
         case (csr_index)
            REG_REC_SIZE: begin
               rec_size_in = csr_wdata[RSZ_W-1:0];
            end
            REG_CHUNK_RECS: begin
               chunk_in = csr_wdata[CNT_W-1:0];
            end
            REG_INITIAL_RECS: begin
               pool_in    = init_sat;
               free_in    = init_sat;
               used_in    = '0;
               sticky_in  = ERR_NONE;
               cur_row_in = '0;
               state_in   = S_INIT;
            end
            REG_PAGE_RECS: begin
               page_in = csr_wdata[CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_INIT;
         rec_size_ff <= REC_SIZE_RST;
         chunk_ff    <= RECS_RST;
         page_ff     <= RECS_RST;
         pool_ff     <= RECS_RST;
         free_ff     <= RECS_RST;
         used_ff     <= '0;
         sticky_ff   <= ERR_NONE;
         cur_row_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         rec_size_ff <= rec_size_in;
         chunk_ff    <= chunk_in;
         page_ff     <= page_in;
         pool_ff     <= pool_in;
         free_ff     <= free_in;
         used_ff     <= used_in;
         sticky_ff   <= sticky_in;
         cur_row_ff  <= cur_row_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      size_ff    <= size_in;
      rec_ff     <= rec_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
      alloc_ff   <= alloc_in;
      hi_row_ff  <= hi_row_in;
      lb_ff      <= lb_in;
      run_ff     <= run_in;
      mn_ff      <= mn_in;
      mx_ff      <= mx_in;
      grow_ff    <= grow_in;
      cut_ff     <= cut_in;
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = (state_ff == S_RESP);
   assign rsp_status       = status_ff;
   assign rsp_granted      = granted_ff;
   assign rsp_is_allocated = alloc_ff;
   assign rsp_free_total   = free_ff;
   assign rsp_used_total   = used_ff;
   assign rsp_pool_size    = pool_ff;

   `SFL_ASSERT(a_count_sum, ({1'b0, free_ff} + {1'b0, used_ff}) == {1'b0, pool_ff}, "free plus used differs from pool size")
   `SFL_ASSERT(a_pool_range, pool_ff != '0 && pool_ff <= CNT_W'(MAX_RECS), "pool size out of range")
   `SFL_ASSERT(a_one_side, !(req_ready && rsp_valid), "request and result sides open together")
   `SFL_ASSERT_NEXT(a_alloc_count, state_ff == S_AL_WR, used_ff == $past(used_ff) + CNT_W'(1), "allocate did not count a used record")
endmodule
